// ----- rtl/cvrp_route_cost_evaluator_top_defines.svh -----
// Assertion macros used by the route cost evaluator checker.
`ifndef CVRP_ROUTE_COST_EVALUATOR_TOP_DEFINES_SVH
`define CVRP_ROUTE_COST_EVALUATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CVRP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CVRP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cvrp_pkg.sv -----
// Shared types and constants of the route cost evaluator.
`timescale 1ns / 1ps

package cvrp_pkg;

    localparam int NODES      = 64;
    localparam int NODE_W     = $clog2(NODES);
    localparam int DIST_WIDTH = 32;
    localparam int COST_W     = 48;
    localparam int SUM_W      = COST_W + 1;
    localparam int LOAD_W     = 16;
    localparam int FIELD_NODE_W = 6;
    localparam int DATA_W     = 32;
    localparam int OP_W       = 2;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 64;
    localparam int M_TUSER_W  = 2;

    typedef logic [NODE_W-1:0]     node_t;
    typedef logic [2*NODE_W-1:0]   dist_addr_t;
    typedef logic [DIST_WIDTH-1:0] dist_t;
    typedef logic [COST_W-1:0]     cost_t;
    typedef logic [SUM_W-1:0]      sum_t;
    typedef logic [LOAD_W-1:0]     load_t;

    typedef enum logic [OP_W-1:0] {
        OP_WR_DEMAND = 2'd0,
        OP_WR_DIST   = 2'd1,
        OP_VISIT     = 2'd2,
        OP_FINISH    = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [S_TDATA_W-2*FIELD_NODE_W-DATA_W-1:0] pad;
        logic [DATA_W-1:0]       data_word;
        logic [FIELD_NODE_W-1:0] other_node;
        logic [FIELD_NODE_W-1:0] node;
    } in_data_t;

    typedef struct packed {
        cost_t route_cost;
        load_t remaining_load;
    } out_data_t;

    typedef struct packed {
        logic  add;
        logic  last;
        logic  status;
        logic  depot_return;
        logic  route_done;
        load_t load;
    } step_info_t;

endpackage

// ----- rtl/cvrp_route_cost_evaluator_top.sv -----
// Route cost evaluator: demand/distance tables, greedy split with depot returns.
`timescale 1ns / 1ps
// Pipeline: accepted item in the B registers, distance table read into the C registers,
// result in the output registers; a visit that forces a depot return issues twice.
// Throughput: one item per cycle while the output is not stalled; a visit with a depot
// return holds the single distance table port for both issues, so the next item waits.
// Reset (aresetn low, synchronous): capacity, load, cost and node go to zero, the
// pipeline empties; table contents are kept and are undefined until written.
module cvrp_route_cost_evaluator_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // node[5:0], other_node[11:6], data_word[43:12], zero[47:44]
    input  logic [cvrp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [cvrp_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // remaining_load[15:0], route_cost[63:16]
    output logic [cvrp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status[0], depot_return[1]
    output logic [cvrp_pkg::M_TUSER_W-1:0] m_axis_tuser,
    output logic                           m_axis_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cvrp_pkg::LOAD_W-1:0]    cfg_data
);

    cvrp_pkg::in_data_t in_fields;
    cvrp_pkg::opcode_t  in_op;
    cvrp_pkg::node_t    in_node;
    logic               in_acc;
    logic               adv;

    cvrp_pkg::load_t    dem_mem [cvrp_pkg::NODES];
    cvrp_pkg::load_t    dem_rdata_reg;
    cvrp_pkg::dist_t    dist_mem [cvrp_pkg::NODES * cvrp_pkg::NODES];
    cvrp_pkg::dist_t    dist_rdata_reg;

    logic               b_valid_reg;
    logic               b_phase_reg;
    cvrp_pkg::opcode_t  b_op_reg;
    cvrp_pkg::node_t    b_node_reg;
    cvrp_pkg::node_t    b_other_reg;
    cvrp_pkg::dist_t    b_data_reg;

    cvrp_pkg::load_t    cap_reg;
    cvrp_pkg::load_t    load_left_reg;
    cvrp_pkg::load_t    load_left_next;
    cvrp_pkg::node_t    cur_node_reg;
    cvrp_pkg::node_t    cur_node_next;
    cvrp_pkg::cost_t    cost_reg;

    logic               issue;
    logic               dist_rd;
    logic               dist_we;
    cvrp_pkg::dist_addr_t dist_addr;
    cvrp_pkg::step_info_t step;
    logic               skip;
    logic               need_ret;

    logic                 c_valid_reg;
    cvrp_pkg::step_info_t c_info_reg;
    cvrp_pkg::sum_t       cost_sum;
    cvrp_pkg::cost_t      cost_sat;

    logic               out_valid_reg;
    logic               out_status_reg;
    logic               out_depot_reg;
    logic               out_done_reg;
    cvrp_pkg::load_t    out_load_reg;
    cvrp_pkg::cost_t    out_cost_reg;
    cvrp_pkg::out_data_t out_fields;

    assign in_fields = cvrp_pkg::in_data_t'(s_axis_tdata);
    assign in_op     = cvrp_pkg::opcode_t'(s_axis_tuser);
    assign in_node   = cvrp_pkg::node_t'(in_fields.node);
    assign adv       = !out_valid_reg || m_axis_tready;
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !b_valid_reg || (adv && step.last);
    assign cfg_ready = 1'b1;
    assign issue     = b_valid_reg && adv;

    // demand table: write or read at accept
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            if (in_op == cvrp_pkg::OP_WR_DEMAND) begin
                dem_mem[in_node] <= in_fields.data_word[cvrp_pkg::LOAD_W-1:0];
            end else begin
                dem_rdata_reg <= dem_mem[in_node];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            b_phase_reg <= 1'b0;
        end else if (in_acc) begin
            b_valid_reg <= 1'b1;
            b_phase_reg <= 1'b0;
        end else if (issue) begin
            if (step.last) begin
                b_valid_reg <= 1'b0;
            end else begin
                b_phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            b_op_reg    <= in_op;
            b_node_reg  <= in_node;
            b_other_reg <= cvrp_pkg::node_t'(in_fields.other_node);
            b_data_reg  <= cvrp_pkg::dist_t'(in_fields.data_word);
        end
    end

    assign skip     = dem_rdata_reg > cap_reg;
    assign need_ret = !skip && (dem_rdata_reg > load_left_reg);

    always_comb begin
        step          = '0;
        dist_rd       = 1'b0;
        dist_we       = 1'b0;
        dist_addr     = {cur_node_reg, cvrp_pkg::node_t'(0)};
        load_left_next = load_left_reg;
        cur_node_next = cur_node_reg;
        case (b_op_reg)
            cvrp_pkg::OP_WR_DEMAND: begin
                step.last = 1'b1;
            end
            cvrp_pkg::OP_WR_DIST: begin
                step.last = 1'b1;
                dist_we   = 1'b1;
                dist_addr = {b_node_reg, b_other_reg};
            end
            cvrp_pkg::OP_VISIT: begin
                if (skip) begin
                    step.last   = 1'b1;
                    step.status = 1'b1;
                end else if (need_ret) begin
                    step.add       = 1'b1;
                    dist_rd        = 1'b1;
                    load_left_next = cap_reg;
                    cur_node_next  = '0;
                end else begin
                    step.add          = 1'b1;
                    step.last         = 1'b1;
                    step.depot_return = b_phase_reg;
                    dist_rd           = 1'b1;
                    dist_addr         = {cur_node_reg, b_node_reg};
                    load_left_next    = load_left_reg - dem_rdata_reg;
                    cur_node_next     = b_node_reg;
                end
            end
            cvrp_pkg::OP_FINISH: begin
                step.add        = 1'b1;
                step.last       = 1'b1;
                step.route_done = 1'b1;
                dist_rd         = 1'b1;
                load_left_next  = cap_reg;
                cur_node_next   = '0;
            end
            default: begin
                step.last = 1'b1;
            end
        endcase
        step.load = load_left_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= '0;
            load_left_reg <= '0;
            cur_node_reg  <= '0;
        end else if (cfg_valid) begin
            cap_reg       <= cfg_data;
            load_left_reg <= cfg_data;
        end else if (issue) begin
            load_left_reg <= load_left_next;
            cur_node_reg  <= cur_node_next;
        end
    end

    // distance table: one access per cycle
    always_ff @(posedge aclk) begin
        if (issue && dist_we) begin
            dist_mem[dist_addr] <= b_data_reg;
        end else if (issue && dist_rd) begin
            dist_rdata_reg <= dist_mem[dist_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            c_info_reg <= step;
        end
    end

    assign cost_sum = cvrp_pkg::sum_t'(cost_reg)
                    + (c_info_reg.add ? cvrp_pkg::sum_t'(dist_rdata_reg) : '0);
    assign cost_sat = cost_sum[cvrp_pkg::COST_W] ? '1
                    : cost_sum[cvrp_pkg::COST_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cost_reg <= '0;
        end else if (adv && c_valid_reg) begin
            cost_reg <= c_info_reg.route_done ? '0 : cost_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= c_valid_reg && c_info_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && c_valid_reg && c_info_reg.last) begin
            out_status_reg <= c_info_reg.status;
            out_depot_reg  <= c_info_reg.depot_return;
            out_done_reg   <= c_info_reg.route_done;
            out_load_reg   <= c_info_reg.load;
            out_cost_reg   <= cost_sat;
        end
    end

    assign out_fields.route_cost     = out_cost_reg;
    assign out_fields.remaining_load = out_load_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_fields;
    assign m_axis_tuser  = {out_depot_reg, out_status_reg};
    assign m_axis_tlast  = out_done_reg;

endmodule

// ----- rtl/cvrp_checker.sv -----
// Port-level checker for the route cost evaluator, bound to the top level.
`timescale 1ns / 1ps
`include "cvrp_route_cost_evaluator_top_defines.svh"

module cvrp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [cvrp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [cvrp_pkg::M_TUSER_W-1:0] m_axis_tuser,
    input logic                           m_axis_tlast,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [cvrp_pkg::LOAD_W-1:0]    cfg_data
);

    cvrp_pkg::load_t     cap_seen_reg;
    cvrp_pkg::load_t     cap_seen_next;
    cvrp_pkg::out_data_t res;

    assign res = cvrp_pkg::out_data_t'(m_axis_tdata);

    always_comb begin
        cap_seen_next = cap_seen_reg;
        if (cfg_valid && cfg_ready) begin
            cap_seen_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_seen_reg <= '0;
        end else begin
            cap_seen_reg <= cap_seen_next;
        end
    end

    `CVRP_ASSERT_NXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `CVRP_ASSERT_IMP(a_finish_refill, aclk, aresetn, m_axis_tvalid && m_axis_tlast, res.remaining_load == cap_seen_reg, "finish result does not show refilled load")
    `CVRP_ASSERT_IMP(a_load_bound, aclk, aresetn, m_axis_tvalid, res.remaining_load <= cap_seen_reg, "remaining load above capacity")
    `CVRP_ASSERT_IMP(a_skip_clean, aclk, aresetn, m_axis_tvalid && m_axis_tuser[0], !m_axis_tuser[1] && !m_axis_tlast, "skipped visit flagged as return or finish")

endmodule

bind cvrp_route_cost_evaluator_top cvrp_checker u_cvrp_checker (.*);
